### hw/rtl/bxavg_pkg.sv
// Shared constants, types and tables of the box average downsampler.
package bxavg_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int FRAC_W        = 16;
  localparam int RECIP_W       = 17;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_LEVEL_DEF = 8;
  localparam int LEVEL_LIMIT   = 16;

  localparam int LEVEL_CFG_W   = 4;
  localparam int WIDTH_CFG_W   = 11;
  localparam int HEIGHT_CFG_W  = 13;
  localparam int CHAN_CFG_W    = 9;
  localparam int CFG_DATA_W    = 13;
  localparam int CFG_INDEX_W   = 2;

  localparam int HEIGHT_LIMIT  = 4096;
  localparam int CHANNEL_LIMIT = 256;
  localparam int ROW_W         = 12;
  localparam int CHAN_W        = 8;

  localparam int RESET_LEVEL   = 2;
  localparam int RESET_WIDTH   = 1024;
  localparam int RESET_HEIGHT  = 512;
  localparam int RESET_CHANS   = 128;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LEVEL         = 2'd0,
    REG_MAP_WIDTH     = 2'd1,
    REG_MAP_HEIGHT    = 2'd2,
    REG_CHANNEL_COUNT = 2'd3
  } cfg_reg_t;

  // per-word block status handed from position tracking to the accumulator
  typedef struct packed {
    logic first;  // start a new block sum
    logic emit;   // word completes a result
    logic wr;     // word belongs to a whole block, update column sum
    logic done;   // result is the last of the map
  } blk_flags_t;

  // round(65536 / level^2); levels 0 and 1 pass the word through
  localparam logic [RECIP_W-1:0] RECIP_TABLE [0:LEVEL_LIMIT] = '{
    17'd65536, 17'd65536, 17'd16384, 17'd7282, 17'd4096, 17'd2621,
    17'd1820,  17'd1337,  17'd1024,  17'd809,  17'd655,  17'd542,
    17'd455,   17'd388,   17'd334,   17'd291,  17'd256
  };

endpackage

### hw/rtl/bxavg_in_if.sv
// Input channel: one feature sample per word.
interface bxavg_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [bxavg_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

### hw/rtl/bxavg_out_if.sv
// Output channel: one pooled value and end-of-map mark per word.
interface bxavg_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bxavg_pkg::SAMPLE_W-1:0] pooled;
  logic                                map_done;

  modport source (output valid, output pooled, output map_done, input ready);
  modport sink   (input valid, input pooled, input map_done, output ready);
endinterface

### hw/rtl/bxavg_position.sv
// Map position counters and per-word block classification.
module bxavg_position #(
  parameter int MAX_WIDTH = bxavg_pkg::MAX_WIDTH_DEF,
  parameter int MAX_LEVEL = bxavg_pkg::MAX_LEVEL_DEF,
  localparam int LW  = $clog2(MAX_LEVEL + 1),
  localparam int WEW = $clog2(MAX_WIDTH + 1),
  localparam int AW  = $clog2(MAX_WIDTH / 2)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               clear,
  input  logic                               step,
  input  logic [LW-1:0]                      lv,
  input  logic [WEW-1:0]                     width,
  input  logic [bxavg_pkg::HEIGHT_CFG_W-1:0] height,
  input  logic [bxavg_pkg::CHAN_CFG_W-1:0]   chans,
  output logic [AW-1:0]                      addr,
  output bxavg_pkg::blk_flags_t              flags
);

  localparam int DW  = $clog2(MAX_LEVEL);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CSW = WEW + 2;
  localparam int RSW = bxavg_pkg::HEIGHT_CFG_W + 1;

  logic [CW-1:0]                 col_pos;
  logic [CW-1:0]                 col_start;
  logic [bxavg_pkg::ROW_W-1:0]   row_pos;
  logic [bxavg_pkg::ROW_W-1:0]   row_start;
  logic [bxavg_pkg::CHAN_W-1:0]  chan_pos;
  logic [DW-1:0]                 dx;
  logic [DW-1:0]                 dy;
  logic [AW-1:0]                 bx;

  logic pass, dx_last, dy_last, col_end, row_end, chan_end;
  logic col_whole, col_lastb, row_whole, row_lastb;
  logic [CSW-1:0] col_lv;
  logic [RSW-1:0] row_lv;

  always_comb begin
    pass     = lv < LW'(2);
    dx_last  = LW'(dx) == lv - LW'(1);
    dy_last  = LW'(dy) == lv - LW'(1);
    col_end  = WEW'(col_pos) == width - WEW'(1);
    row_end  = bxavg_pkg::HEIGHT_CFG_W'(row_pos) == height - bxavg_pkg::HEIGHT_CFG_W'(1);
    chan_end = bxavg_pkg::CHAN_CFG_W'(chan_pos) == chans - bxavg_pkg::CHAN_CFG_W'(1);

    col_lv    = CSW'(lv);
    row_lv    = RSW'(lv);
    col_whole = CSW'(col_start) + col_lv <= CSW'(width);
    col_lastb = CSW'(col_start) + (col_lv << 1) > CSW'(width);
    row_whole = RSW'(row_start) + row_lv <= RSW'(height);
    row_lastb = RSW'(row_start) + (row_lv << 1) > RSW'(height);

    addr        = bx;
    flags.wr    = !pass && col_whole && row_whole;
    flags.first = pass || (dx == '0 && dy == '0);
    flags.emit  = pass || (flags.wr && dx_last && dy_last);
    flags.done  = chan_end && (pass ? (row_end && col_end) : (row_lastb && col_lastb));
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      col_pos   <= '0;
      col_start <= '0;
      row_pos   <= '0;
      row_start <= '0;
      chan_pos  <= '0;
      dx        <= '0;
      dy        <= '0;
      bx        <= '0;
    end else if (step) begin
      if (col_end) begin
        col_pos   <= '0;
        col_start <= '0;
        dx        <= '0;
        bx        <= '0;
        if (row_end) begin
          row_pos   <= '0;
          row_start <= '0;
          dy        <= '0;
          chan_pos  <= chan_end ? '0 : chan_pos + 1'b1;
        end else begin
          row_pos <= row_pos + 1'b1;
          if (dy_last) begin
            dy        <= '0;
            row_start <= bxavg_pkg::ROW_W'(row_start + row_lv);
          end else begin
            dy <= dy + 1'b1;
          end
        end
      end else begin
        col_pos <= col_pos + 1'b1;
        if (dx_last) begin
          dx        <= '0;
          bx        <= bx + 1'b1;
          col_start <= CW'(col_start + col_lv);
        end else begin
          dx <= dx + 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/bxavg_accum.sv
// Column sum memory with read-modify-write stage and block sum register.
module bxavg_accum #(
  parameter int MAX_WIDTH = bxavg_pkg::MAX_WIDTH_DEF,
  parameter int MAX_LEVEL = bxavg_pkg::MAX_LEVEL_DEF,
  localparam int AW    = $clog2(MAX_WIDTH / 2),
  localparam int SUM_W = bxavg_pkg::SAMPLE_W + 2 * $clog2(MAX_LEVEL)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 take,
  output logic                                 ready,
  input  logic signed [bxavg_pkg::SAMPLE_W-1:0] sample,
  input  logic [AW-1:0]                        addr,
  input  bxavg_pkg::blk_flags_t                flags,
  output logic                                 sum_valid,
  input  logic                                 sum_ready,
  output logic signed [SUM_W-1:0]              sum,
  output logic                                 sum_done
);

  localparam int DEPTH = MAX_WIDTH / 2;

  logic signed [SUM_W-1:0] col_mem [DEPTH];

  logic                                 s1_valid;
  logic signed [bxavg_pkg::SAMPLE_W-1:0] s1_sample;
  logic [AW-1:0]                        s1_addr;
  bxavg_pkg::blk_flags_t                s1_flags;
  logic                                 s1_fwd;
  logic signed [SUM_W-1:0]              rd_data;
  logic signed [SUM_W-1:0]              last_sum;

  logic                    s1_go;
  logic signed [SUM_W-1:0] base;
  logic signed [SUM_W-1:0] sum_next;

  always_comb begin
    s1_go    = s1_valid && (!s1_flags.emit || !sum_valid || sum_ready);
    ready    = !s1_valid || s1_go;
    base     = s1_fwd ? last_sum : rd_data;
    sum_next = s1_flags.first ? SUM_W'(s1_sample) : base + SUM_W'(s1_sample);
  end

  // read-before-write; a word reading the entry written at the same edge forwards
  always_ff @(posedge clk) begin
    if (s1_go && s1_flags.wr) begin
      col_mem[s1_addr] <= sum_next;
    end
    if (take) begin
      rd_data <= col_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_flags.wr) begin
      last_sum <= sum_next;
    end
    if (take) begin
      s1_sample <= sample;
      s1_addr   <= addr;
      s1_flags  <= flags;
      s1_fwd    <= s1_go && s1_flags.wr && (s1_addr == addr);
    end
    if (s1_go && s1_flags.emit) begin
      sum      <= sum_next;
      sum_done <= s1_flags.done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go && s1_flags.emit) begin
        sum_valid <= 1'b1;
      end else if (sum_ready) begin
        sum_valid <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/bxavg_scale.sv
// Reciprocal multiply, rounding and saturation to the output register.
module bxavg_scale #(
  parameter int SUM_W = bxavg_pkg::SAMPLE_W + 6
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sum_valid,
  output logic                                sum_ready,
  input  logic signed [SUM_W-1:0]             sum,
  input  logic                                sum_done,
  input  logic [bxavg_pkg::RECIP_W-1:0]       recip,
  bxavg_out_if.source                         out_ch
);

  localparam int PW = SUM_W + bxavg_pkg::RECIP_W + 1;
  localparam int SW = bxavg_pkg::SAMPLE_W;
  localparam logic signed [PW-1:0] HALF  = PW'(1) <<< (bxavg_pkg::FRAC_W - 1);
  localparam logic signed [PW-1:0] MAX_V = PW'((1 << (SW - 1)) - 1);
  localparam logic signed [PW-1:0] MIN_V = -PW'(1 << (SW - 1));

  logic                    p_valid;
  logic signed [PW-1:0]    prod;
  logic                    p_done;

  logic                    o_ready;
  logic                    p_ready;
  logic signed [PW-1:0]    prod_next;
  logic signed [PW-1:0]    rounded;
  logic signed [SW-1:0]    pooled_next;

  always_comb begin
    o_ready   = !out_ch.valid || out_ch.ready;
    p_ready   = !p_valid || o_ready;
    sum_ready = p_ready;
    prod_next = PW'(sum) * $signed(PW'(recip));
    rounded   = (prod + HALF) >>> bxavg_pkg::FRAC_W;
    if (rounded > MAX_V) begin
      pooled_next = SW'(MAX_V);
    end else if (rounded < MIN_V) begin
      pooled_next = SW'(MIN_V);
    end else begin
      pooled_next = SW'(rounded);
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid && p_ready) begin
      prod   <= prod_next;
      p_done <= sum_done;
    end
    if (p_valid && o_ready) begin
      out_ch.pooled   <= pooled_next;
      out_ch.map_done <= p_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid      <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (p_ready) begin
        p_valid <= sum_valid;
      end
      if (o_ready) begin
        out_ch.valid <= p_valid;
      end
    end
  end

endmodule

### hw/rtl/box_average_downsampler.sv
// Top level: non-overlapping box average downsampler of a streamed feature map.
// Throughput: one word per cycle in while the output accepts results; back-pressure from the output stalls the input.
// Path: the word that completes a block passes the read-modify-write stage, block sum, product and output registers.
// Pace set by the column sum read-modify-write, one read and one write a cycle, with forwarding.
// Reset: registers take their defaults, map position returns to zero, pipeline empties.
// Column sums are not cleared; the first word of every whole block overwrites its entry.
module box_average_downsampler #(
  parameter int MAX_WIDTH = bxavg_pkg::MAX_WIDTH_DEF,
  parameter int MAX_LEVEL = bxavg_pkg::MAX_LEVEL_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [bxavg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bxavg_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
  bxavg_in_if.sink                          in_ch,
  bxavg_out_if.source                       out_ch
);

  localparam int LW    = $clog2(MAX_LEVEL + 1);
  localparam int WEW   = $clog2(MAX_WIDTH + 1);
  localparam int AW    = $clog2(MAX_WIDTH / 2);
  localparam int SUM_W = bxavg_pkg::SAMPLE_W + 2 * $clog2(MAX_LEVEL);
  localparam int HW    = bxavg_pkg::HEIGHT_CFG_W;
  localparam int CHW   = bxavg_pkg::CHAN_CFG_W;
  localparam int RST_W = (MAX_WIDTH < bxavg_pkg::RESET_WIDTH) ? MAX_WIDTH
                                                              : bxavg_pkg::RESET_WIDTH;

  logic [LW-1:0]                    lv;
  logic [WEW-1:0]                   width;
  logic [HW-1:0]                    height;
  logic [CHW-1:0]                   chans;
  logic [bxavg_pkg::RECIP_W-1:0]    recip;

  logic [4:0]       lv_in;
  logic [LW-1:0]    lv_new;
  logic [WEW-1:0]   width_new;
  logic [HW-1:0]    height_new;
  logic [CHW-1:0]   chans_new;

  logic                      take;
  logic                      acc_ready;
  logic [AW-1:0]             addr;
  bxavg_pkg::blk_flags_t     flags;
  logic                      sum_valid;
  logic                      sum_ready;
  logic signed [SUM_W-1:0]   sum;
  logic                      sum_done;

  logic [bxavg_pkg::WIDTH_CFG_W-1:0] w_in;
  logic [HW-1:0]                     h_in;
  logic [CHW-1:0]                    c_in;

  always_comb begin
    lv_in  = {1'b0, cfg_wr_data[bxavg_pkg::LEVEL_CFG_W-1:0]};
    lv_new = (lv_in > 5'(MAX_LEVEL)) ? LW'(MAX_LEVEL) : LW'(lv_in);

    w_in = cfg_wr_data[bxavg_pkg::WIDTH_CFG_W-1:0];
    if (w_in == '0) begin
      width_new = WEW'(1);
    end else if (14'(w_in) > 14'(MAX_WIDTH)) begin
      width_new = WEW'(MAX_WIDTH);
    end else begin
      width_new = WEW'(w_in);
    end

    h_in = cfg_wr_data[HW-1:0];
    if (h_in == '0) begin
      height_new = HW'(1);
    end else if (h_in > HW'(bxavg_pkg::HEIGHT_LIMIT)) begin
      height_new = HW'(bxavg_pkg::HEIGHT_LIMIT);
    end else begin
      height_new = h_in;
    end

    c_in = cfg_wr_data[CHW-1:0];
    if (c_in == '0) begin
      chans_new = CHW'(1);
    end else if (c_in > CHW'(bxavg_pkg::CHANNEL_LIMIT)) begin
      chans_new = CHW'(bxavg_pkg::CHANNEL_LIMIT);
    end else begin
      chans_new = c_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lv     <= LW'(bxavg_pkg::RESET_LEVEL);
      width  <= WEW'(RST_W);
      height <= HW'(bxavg_pkg::RESET_HEIGHT);
      chans  <= CHW'(bxavg_pkg::RESET_CHANS);
      recip  <= bxavg_pkg::RECIP_TABLE[bxavg_pkg::RESET_LEVEL];
    end else if (cfg_wr_en) begin
      case (bxavg_pkg::cfg_reg_t'(cfg_index))
        bxavg_pkg::REG_LEVEL: begin
          lv    <= lv_new;
          recip <= bxavg_pkg::RECIP_TABLE[5'(lv_new)];
        end
        bxavg_pkg::REG_MAP_WIDTH:     width  <= width_new;
        bxavg_pkg::REG_MAP_HEIGHT:    height <= height_new;
        bxavg_pkg::REG_CHANNEL_COUNT: chans  <= chans_new;
        default: ;
      endcase
    end
  end

  assign take        = in_ch.valid && acc_ready;
  assign in_ch.ready = acc_ready;

  bxavg_position #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_LEVEL (MAX_LEVEL)
  ) u_position (
    .clk    (clk),
    .rst    (rst),
    .clear  (cfg_wr_en),
    .step   (take),
    .lv     (lv),
    .width  (width),
    .height (height),
    .chans  (chans),
    .addr   (addr),
    .flags  (flags)
  );

  bxavg_accum #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_LEVEL (MAX_LEVEL)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .ready     (acc_ready),
    .sample    (in_ch.sample),
    .addr      (addr),
    .flags     (flags),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum),
    .sum_done  (sum_done)
  );

  bxavg_scale #(
    .SUM_W (SUM_W)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum),
    .sum_done  (sum_done),
    .recip     (recip),
    .out_ch    (out_ch)
  );

endmodule

### hw/rtl/bxavg_checker.sv
// Port-level checks of the box average downsampler, bound to the top level.
module bxavg_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [bxavg_pkg::SAMPLE_W-1:0] pooled,
  input logic                                 map_done
);

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

  // an empty output register leaves room for a new input word
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_ready_after_reset: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pooled) && $stable(map_done))
    else $error("stalled result word changed");

endmodule

bind box_average_downsampler bxavg_checker u_bxavg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .pooled    (out_ch.pooled),
  .map_done  (out_ch.map_done)
);
